### sv/assert_macros.svh
// Assertion helpers for the RTL; mlp_online_backprop is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/mlpbp_pkg.sv
`timescale 1ns / 1ps
package mlpbp_pkg;

  localparam int ACC_W  = 53;
  localparam int MA_W   = 29;
  localparam int MB_W   = 24;
  localparam int Q_ONE  = 4096;
  localparam int Q_HALF = 2048;

  localparam logic [14:0] LR_RESET = 15'd2048;

  localparam logic [1:0] OP_INFER = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HB, ST_HX0, ST_HX1, ST_OB, ST_OMAC, ST_OLUT,
    ST_TP, ST_TD, ST_TLD, ST_TOB,
    ST_JDV, ST_JDH, ST_JV, ST_JVW, ST_JB, ST_JW0, ST_JW1,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctl_t;

  // Restoring division, only evaluated while building the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid sample at x = -8 + 16*idx/depth, rounded to Q0.12.
  function automatic logic [12:0] sig_entry(input int idx, input int depth);
    logic [63:0] one, h, term, base, e, den, r;
    int m, t;
    one  = 64'd1 << 30;
    h    = udiv64(64'd16 << 30, 64'(depth));
    term = one;
    base = one;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * h) >> 30, 64'(k));
      if (k[0]) base = base - term;
      else base = base + term;
    end
    m = idx - (depth >>> 1);
    t = (m < 0) ? -m : m;
    e = one;
    for (int n = 0; n < t; n++) e = (e * base + (one >> 1)) >> 30;
    den = one + e;
    if (m >= 0) r = udiv64((64'd4096 << 30) + (den >> 1), den);
    else r = udiv64(64'd4096 * e + (den >> 1), den);
    return r[12:0];
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] w,
                                                 input logic signed [23:0] dlt);
    logic signed [24:0] s;
    s = 25'(w) + 25'(dlt);
    if (s > 25'sd32767) return 16'sh7fff;
    if (s < -25'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

endpackage

### sv/mlpbp_in_if.sv
`timescale 1ns / 1ps
interface mlpbp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] x0;
  logic signed [15:0] x1;
  logic [12:0]        target;
  logic [4:0]         weight_index;
  logic signed [15:0] weight_value;

  modport source(output valid, op, x0, x1, target, weight_index, weight_value,
                 input ready);
  modport sink(input valid, op, x0, x1, target, weight_index, weight_value,
               output ready);
endinterface

### sv/mlpbp_out_if.sv
`timescale 1ns / 1ps
interface mlpbp_out_if;
  logic               valid;
  logic               ready;
  logic [12:0]        net_output;
  logic               class_bit;
  logic signed [13:0] output_error;
  logic signed [15:0] read_value;

  modport source(output valid, net_output, class_bit, output_error, read_value,
                 input ready);
  modport sink(input valid, net_output, class_bit, output_error, read_value,
               output ready);
endinterface

### sv/mlpbp_mac.sv
`timescale 1ns / 1ps
module mlpbp_mac import mlpbp_pkg::*; (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [MA_W-1:0]  a,
  input  logic signed [MB_W-1:0]  b,
  input  logic signed [ACC_W-1:0] addend,
  output logic signed [ACC_W-1:0] acc_r
);

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_nxt;

  assign prod = a * b;

  always_comb begin
    acc_nxt = (ctl.accum ? acc_r : addend) + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) acc_r <= acc_nxt;
  end

endmodule

### sv/mlpbp_sig.sv
`timescale 1ns / 1ps
module mlpbp_sig import mlpbp_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic signed [ACC_W-1:0] acc,
  output logic [12:0]             y
);

  localparam int IW = $clog2(DEPTH);
  localparam int PW = 16 + IW;

  logic [12:0]               rom [DEPTH];
  logic signed [ACC_W-13:0]  a;
  logic [15:0]               u;
  logic [PW-1:0]             p;
  logic [IW-1:0]             idx;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    localparam logic [12:0] ENT = sig_entry(gi, DEPTH);
    assign rom[gi] = ENT;
  end

  // Floor of acc / 4096, clamped to 16 bits, then offset to unsigned.
  always_comb begin
    a = acc[ACC_W-1:12];
    if (a > (ACC_W-12)'(32767)) u = 16'hffff;
    else if (a < -(ACC_W-12)'(32768)) u = 16'h0000;
    else u = a[15:0] ^ 16'h8000;
    p   = PW'(u) * PW'(DEPTH);
    idx = p[PW-1:16];
    y   = rom[idx];
  end

endmodule

### sv/mlp_online_backprop.sv
`timescale 1ns / 1ps
// Two-input, N_HIDDEN-hidden, one-output sigmoid network in Q4.12 with online training.
// in_ch carries one transaction per item: op (infer, train, write weight, read weight),
// the inputs x0/x1, the training target and a weight index/value. out_ch returns one
// transaction per item with the network output, its class, the error and a read value.
// cfg_we/cfg_wdata load the learning rate; write it only while the block is idle.
// All network products run on one multiply-accumulate unit under a small sequencer, at
// most one product per cycle. Infer, write and read run only the forward pass; train adds
// the output delta steps and the seven MAC steps per hidden unit of the weight update.
// After each item the sequencer returns to idle before it accepts the next one.
// in_ch.ready is high only while the sequencer is idle, so one item is in work at a time.
// The result sits in an output register; the next item is accepted while it waits, and
// the sequencer holds in its last step if the receiver still stalls the previous result.
// Synchronous reset clears all weights to zero and sets the learning rate to 0.5.
`include "assert_macros.svh"
module mlp_online_backprop import mlpbp_pkg::*; #(
  parameter int N_HIDDEN        = 5,
  parameter int SIG_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  mlpbp_in_if.sink    in_ch,
  mlpbp_out_if.source out_ch
);

  localparam int NW = 4 * N_HIDDEN + 1;
  localparam int AW = $clog2(NW);
  localparam int JW = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
  localparam int AV = 2 * N_HIDDEN;
  localparam int AB = 3 * N_HIDDEN;
  localparam int AO = 4 * N_HIDDEN;

  st_t                state_r, state_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic [14:0]        lr_r;

  logic [1:0]         op_r;
  logic signed [15:0] x0_r, x1_r, wv_r;
  logic [12:0]        tgt_r;
  logic [4:0]         widx_r;

  logic [12:0]        y_r, y_nxt;
  logic signed [13:0] err_r, err_nxt;
  logic signed [11:0] d_r, d_nxt;
  logic signed [26:0] ld_r, ld_nxt;
  logic signed [23:0] q_r, q_nxt;
  logic signed [12:0] dh_r, dh_nxt;
  logic signed [27:0] ldh_r, ldh_nxt;

  logic signed [15:0] wt_r [NW];
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [15:0] wr_data, rd_data;

  logic [12:0]        h_r [N_HIDDEN];
  logic               h_we;
  logic [JW-1:0]      h_widx, h_ridx;
  logic [12:0]        h_cur;

  mac_ctl_t                mac_ctl;
  logic signed [MA_W-1:0]  mac_a;
  logic signed [MB_W-1:0]  mac_b;
  logic signed [ACC_W-1:0] mac_add;
  logic signed [ACC_W-1:0] acc;
  logic [12:0]             sig_y;

  logic               out_valid_r, out_valid_nxt, out_load;
  logic [12:0]        out_y_r;
  logic signed [13:0] out_err_r;
  logic signed [15:0] out_rd_r;

  logic               accept, j_last, widx_ok;
  logic [12:0]        tgt_c;

  mlpbp_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .acc_r  (acc)
  );

  mlpbp_sig #(.DEPTH(SIG_TABLE_DEPTH)) u_sig (
    .acc (acc),
    .y   (sig_y)
  );

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign j_last      = (j_r == JW'(N_HIDDEN - 1));
  assign widx_ok     = (32'(widx_r) < 32'(NW));
  assign tgt_c       = (tgt_r > 13'(Q_ONE)) ? 13'(Q_ONE) : tgt_r;
  assign rd_data     = wt_r[rd_addr];
  assign h_cur       = h_r[h_ridx];

  assign out_ch.valid        = out_valid_r;
  assign out_ch.net_output   = out_y_r;
  assign out_ch.class_bit    = (out_y_r >= 13'(Q_HALF));
  assign out_ch.output_error = out_err_r;
  assign out_ch.read_value   = out_rd_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    y_nxt     = y_r;
    err_nxt   = err_r;
    d_nxt     = d_r;
    ld_nxt    = ld_r;
    q_nxt     = q_r;
    dh_nxt    = dh_r;
    ldh_nxt   = ldh_r;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    mac_add   = '0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    h_we      = 1'b0;
    h_widx    = j_r;
    h_ridx    = j_r;
    out_load  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HB;
          j_nxt     = '0;
        end
      end
      // The lookup of the previous hidden unit overlaps the bias load of the next.
      ST_HB: begin
        rd_addr     = AW'(AB) + AW'(j_r);
        mac_ctl.en  = 1'b1;
        mac_add     = ACC_W'(rd_data) <<< 12;
        h_we        = (j_r != '0);
        h_widx      = j_r - 1'b1;
        state_nxt   = ST_HX0;
      end
      ST_HX0: begin
        rd_addr       = AW'({j_r, 1'b0});
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MA_W'(x0_r);
        mac_b         = MB_W'(rd_data);
        state_nxt     = ST_HX1;
      end
      ST_HX1: begin
        rd_addr       = AW'({j_r, 1'b1});
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MA_W'(x1_r);
        mac_b         = MB_W'(rd_data);
        if (j_last) begin
          state_nxt = ST_OB;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_HB;
        end
      end
      ST_OB: begin
        h_we       = 1'b1;
        h_widx     = JW'(N_HIDDEN - 1);
        rd_addr    = AW'(AO);
        mac_ctl.en = 1'b1;
        mac_add    = ACC_W'(rd_data) <<< 12;
        j_nxt      = '0;
        state_nxt  = ST_OMAC;
      end
      ST_OMAC: begin
        rd_addr       = AW'(AV) + AW'(j_r);
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MA_W'(h_cur);
        mac_b         = MB_W'(rd_data);
        if (j_last) begin
          j_nxt     = '0;
          state_nxt = ST_OLUT;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_OLUT: begin
        y_nxt     = sig_y;
        err_nxt   = $signed({1'b0, tgt_c}) - $signed({1'b0, sig_y});
        state_nxt = (op_r == OP_TRAIN) ? ST_TP : ST_FIN;
      end
      ST_TP: begin
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(y_r);
        mac_b      = MB_W'(13'(Q_ONE) - y_r);
        state_nxt  = ST_TD;
      end
      ST_TD: begin
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(err_r);
        mac_b      = acc[MB_W-1:0];
        state_nxt  = ST_TLD;
      end
      ST_TLD: begin
        d_nxt      = acc[35:24];
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'($signed(acc[35:24]));
        mac_b      = MB_W'(lr_r);
        state_nxt  = ST_TOB;
      end
      // Output bias update; the multiplier starts the first hidden unit's h*(1-h).
      ST_TOB: begin
        ld_nxt     = acc[26:0];
        rd_addr    = AW'(AO);
        wr_en      = 1'b1;
        wr_addr    = AW'(AO);
        wr_data    = sat_add(rd_data, $signed(acc[35:12]));
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(h_cur);
        mac_b      = MB_W'(13'(Q_ONE) - h_cur);
        state_nxt  = ST_JDV;
      end
      ST_JDV: begin
        q_nxt      = acc[MB_W-1:0];
        rd_addr    = AW'(AV) + AW'(j_r);
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(d_r);
        mac_b      = MB_W'(rd_data);
        state_nxt  = ST_JDH;
      end
      ST_JDH: begin
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'($signed(acc[26:0]));
        mac_b      = q_r;
        state_nxt  = ST_JV;
      end
      ST_JV: begin
        dh_nxt     = acc[48:36];
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(ld_r);
        mac_b      = MB_W'(h_cur);
        state_nxt  = ST_JVW;
      end
      ST_JVW: begin
        rd_addr    = AW'(AV) + AW'(j_r);
        wr_en      = 1'b1;
        wr_addr    = AW'(AV) + AW'(j_r);
        wr_data    = sat_add(rd_data, $signed(acc[47:24]));
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(dh_r);
        mac_b      = MB_W'(lr_r);
        state_nxt  = ST_JB;
      end
      ST_JB: begin
        ldh_nxt    = acc[27:0];
        rd_addr    = AW'(AB) + AW'(j_r);
        wr_en      = 1'b1;
        wr_addr    = AW'(AB) + AW'(j_r);
        wr_data    = sat_add(rd_data, $signed(acc[35:12]));
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'($signed(acc[27:0]));
        mac_b      = MB_W'(x0_r);
        state_nxt  = ST_JW0;
      end
      ST_JW0: begin
        rd_addr    = AW'({j_r, 1'b0});
        wr_en      = 1'b1;
        wr_addr    = AW'({j_r, 1'b0});
        wr_data    = sat_add(rd_data, $signed(acc[47:24]));
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(ldh_r);
        mac_b      = MB_W'(x1_r);
        state_nxt  = ST_JW1;
      end
      ST_JW1: begin
        rd_addr    = AW'({j_r, 1'b1});
        wr_en      = 1'b1;
        wr_addr    = AW'({j_r, 1'b1});
        wr_data    = sat_add(rd_data, $signed(acc[47:24]));
        h_ridx     = j_r + 1'b1;
        mac_ctl.en = 1'b1;
        mac_a      = MA_W'(h_cur);
        mac_b      = MB_W'(13'(Q_ONE) - h_cur);
        if (j_last) begin
          state_nxt = ST_FIN;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_JDV;
        end
      end
      ST_FIN: begin
        rd_addr = widx_ok ? AW'(widx_r) : '0;
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          wr_en         = (op_r == OP_WRITE) && widx_ok;
          wr_addr       = AW'(widx_r);
          wr_data       = wv_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= LR_RESET;
      for (int i = 0; i < NW; i++) wt_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) lr_r <= cfg_wdata;
      if (wr_en) wt_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      x0_r   <= in_ch.x0;
      x1_r   <= in_ch.x1;
      tgt_r  <= in_ch.target;
      widx_r <= in_ch.weight_index;
      wv_r   <= in_ch.weight_value;
    end
    if (h_we) h_r[h_widx] <= sig_y;
    y_r   <= y_nxt;
    err_r <= err_nxt;
    d_r   <= d_nxt;
    ld_r  <= ld_nxt;
    q_r   <= q_nxt;
    dh_r  <= dh_nxt;
    ldh_r <= ldh_nxt;
    if (out_load) begin
      out_y_r   <= y_r;
      out_err_r <= err_r;
      out_rd_r  <= ((op_r == OP_READ) && widx_ok) ? rd_data : 16'sd0;
    end
  end

  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset left block busy")
  `ASSERT_CLK(a_busy_after_accept, accept |=> !in_ch.ready, "ready stayed high after a transaction")
  `ASSERT_CLK(a_result_from_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN), "result outside final step")
  `ASSERT_CLK(a_j_range, (state_r == ST_OMAC) |-> (j_r <= JW'(N_HIDDEN - 1)), "hidden index out of range")

endmodule

### dv/mlp_online_backprop_test.sv
`timescale 1ns / 1ps
module mlp_online_backprop_test;
  import mlpbp_pkg::*;

  localparam int NH = 5;
  localparam int TDEPTH = 256;
  localparam int RANDOM_ITEMS = 900;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic [12:0]        target;
    logic [4:0]         widx;
    logic signed [15:0] wval;
  } net_item_t;

  typedef struct {
    logic [12:0]        y;
    logic               cls;
    logic signed [13:0] err;
    logic signed [15:0] rd;
  } net_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [14:0] cfg_wdata;
  int error_count;

  mlpbp_in_if  in_ch();
  mlpbp_out_if out_ch();

  mlp_online_backprop i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  class network_scoreboard;
    longint w_in[2*NH];
    longint w_out[NH];
    longint b_hid[NH];
    longint b_out;
    longint lr;
    longint sig_rom[TDEPTH];
    net_result_t pending[$];

    function new();
      longint one, h, term, base, e, den;
      int m, t;
      one = 64'd1 << 30;
      h = (16 * one) / TDEPTH;
      term = one;
      base = one;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * h) >>> 30) / k;
        if (k % 2) base -= term; else base += term;
      end
      for (int i = 0; i < TDEPTH; i++) begin
        m = i - TDEPTH / 2;
        t = m < 0 ? -m : m;
        e = one;
        for (int n = 0; n < t; n++) e = (e * base + (one >>> 1)) >>> 30;
        den = one + e;
        if (m >= 0) sig_rom[i] = ((longint'(4096) << 30) + (den >>> 1)) / den;
        else sig_rom[i] = (4096 * e + (den >>> 1)) / den;
      end
      clear_weights();
    endfunction

    function void clear_weights();
      foreach (w_in[i]) w_in[i] = 0;
      foreach (w_out[i]) begin
        w_out[i] = 0;
        b_hid[i] = 0;
      end
      b_out = 0;
      lr = longint'(LR_RESET);
    endfunction

    // Arithmetic shift is a floor for signed longint.
    function longint fl(longint v, int s);
      return v >>> s;
    endfunction

    function longint sat(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint sigmoid(longint a);
      longint idx;
      if (a < -32768) a = -32768;
      if (a > 32767) a = 32767;
      idx = ((a + 32768) * TDEPTH) >>> 16;
      if (idx >= TDEPTH) idx = TDEPTH - 1;
      return sig_rom[idx];
    endfunction

    function void note_input(net_item_t it);
      longint x[2], hid[NH], dh[NH], acc, y, tgt, err, rd, d, wv;
      net_result_t r;
      x[0] = longint'(it.x0);
      x[1] = longint'(it.x1);
      wv = longint'(it.wval);
      tgt = it.target > 4096 ? 4096 : longint'(it.target);
      rd = 0;
      for (int j = 0; j < NH; j++) begin
        acc = b_hid[j] * 4096 + x[0] * w_in[2*j] + x[1] * w_in[2*j+1];
        hid[j] = sigmoid(fl(acc, 12));
      end
      acc = b_out * 4096;
      for (int j = 0; j < NH; j++) acc += hid[j] * w_out[j];
      y = sigmoid(fl(acc, 12));
      err = tgt - y;
      if (it.op == OP_TRAIN) begin
        d = fl(err * y * (4096 - y), 24);
        for (int j = 0; j < NH; j++)
          dh[j] = fl(d * w_out[j] * hid[j] * (4096 - hid[j]), 36);
        for (int j = 0; j < NH; j++) w_out[j] = sat(w_out[j] + fl(lr * d * hid[j], 24));
        b_out = sat(b_out + fl(lr * d, 12));
        for (int j = 0; j < NH; j++) begin
          b_hid[j] = sat(b_hid[j] + fl(lr * dh[j], 12));
          w_in[2*j] = sat(w_in[2*j] + fl(lr * dh[j] * x[0], 24));
          w_in[2*j+1] = sat(w_in[2*j+1] + fl(lr * dh[j] * x[1], 24));
        end
      end else if (it.op == OP_WRITE || it.op == OP_READ) begin
        if (it.widx < 2*NH) begin
          if (it.op == OP_WRITE) w_in[it.widx] = wv; else rd = w_in[it.widx];
        end else if (it.widx < 3*NH) begin
          if (it.op == OP_WRITE) w_out[it.widx-2*NH] = wv;
          else rd = w_out[it.widx-2*NH];
        end else if (it.widx < 4*NH) begin
          if (it.op == OP_WRITE) b_hid[it.widx-3*NH] = wv;
          else rd = b_hid[it.widx-3*NH];
        end else if (it.widx == 4*NH) begin
          if (it.op == OP_WRITE) b_out = wv; else rd = b_out;
        end
      end
      r.y = y[12:0];
      r.cls = y >= Q_HALF;
      r.err = err[13:0];
      r.rd = rd[15:0];
      pending.push_back(r);
    endfunction

    task check_result(net_result_t got);
      net_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, net_output", got.y, -1);
        return;
      end
      want = pending.pop_front();
      if (got.y !== want.y) report_mismatch("net_output", got.y, want.y);
      if (got.cls !== want.cls) report_mismatch("class_bit", got.cls, want.cls);
      if (got.err !== want.err) report_mismatch("output_error", got.err, want.err);
      if (got.rd !== want.rd) report_mismatch("read_value", got.rd, want.rd);
    endtask
  endclass

  network_scoreboard sb;
  int burst_left;
  int stall_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor both channels at the edge; inputs only change after it.
  always @(posedge clk) begin
    net_item_t it;
    net_result_t r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.op = in_ch.op;
        it.x0 = in_ch.x0;
        it.x1 = in_ch.x1;
        it.target = in_ch.target;
        it.widx = in_ch.weight_index;
        it.wval = in_ch.weight_value;
        sb.note_input(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        r.y = out_ch.net_output;
        r.cls = out_ch.class_bit;
        r.err = out_ch.output_error;
        r.rd = out_ch.read_value;
        sb.check_result(r);
      end
    end
  end

  // Receiver stall pattern: periods of free flow alternate with random stalls.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 200) % 2 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // Valid stays high through a burst and drops only after its last transaction.
  task automatic send_item(input net_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.x0 <= it.x0;
    in_ch.x1 <= it.x1;
    in_ch.target <= it.target;
    in_ch.weight_index <= it.widx;
    in_ch.weight_value <= it.wval;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_op(input logic [1:0] op, input int a, input int b, input int tg,
                         input int idx, input int val);
    net_item_t it;
    it.op = op;
    it.x0 = 16'(a);
    it.x1 = 16'(b);
    it.target = 13'(tg);
    it.widx = 5'(idx);
    it.wval = 16'(val);
    send_item(it);
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_rate(input logic [14:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lr = longint'(v);
  endtask

  function automatic int rand_q(input bit wide);
    if (wide) return int'($signed(16'($urandom)));
    return $urandom_range(0, 8192) - 4096;
  endfunction

  initial begin
    sb = new();
    error_count = 0;
    burst_left = 0;
    stall_phase = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_INFER;
    in_ch.x0 = '0;
    in_ch.x1 = '0;
    in_ch.target = '0;
    in_ch.weight_index = '0;
    in_ch.weight_value = '0;
    out_ch.ready = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every op, out-of-range index, target above one.
    send_op(OP_INFER, 0, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 4096, 20, 0);
    send_op(OP_WRITE, 32767, -32768, 8191, 0, 32767);
    send_op(OP_WRITE, 0, 0, 0, 10, -32768);
    send_op(OP_WRITE, 0, 0, 0, 20, 32767);
    send_op(OP_INFER, 32767, -32768, 8191, 31, -1);
    send_op(OP_READ, 0, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 10, 0);
    send_op(OP_READ, 0, 0, 0, 21, 0);
    send_op(OP_WRITE, 0, 0, 0, 31, 1234);
    send_op(OP_TRAIN, -32768, 32767, 0, 0, 0);
    send_op(OP_TRAIN, 4096, 4096, 8191, 0, 0);
    send_op(OP_WRITE, 0, 0, 0, 20, -32768);
    send_op(OP_TRAIN, 0, 0, 4096, 15, 0);
    for (int i = 0; i <= 20; i += 5) send_op(OP_READ, 0, 0, 0, i, 0);

    // Pause until all results have come back before changing the rate.
    set_rate(15'h7fff);
    for (int p = 0; p < 4; p++) begin
      if (p == 1) set_rate(15'd0);
      if (p == 2) set_rate(15'($urandom_range(1, 8192)));
      if (p == 3) set_rate(LR_RESET);
      // Each phase starts from a random, mostly moderate network.
      for (int k = 0; k <= 20; k++)
        send_op(OP_WRITE, 0, 0, 0, k, rand_q(($urandom_range(0, 9) == 0)));
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        int sel;
        logic [1:0] op;
        sel = $urandom_range(0, 99);
        op = sel < 50 ? OP_TRAIN : sel < 70 ? OP_INFER : sel < 85 ? OP_READ : OP_WRITE;
        send_op(op, rand_q(($urandom_range(0, 4) == 0)), rand_q(($urandom_range(0, 4) == 0)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, 4096),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, 20),
                rand_q(($urandom_range(0, 4) == 0)));
      end
    end

    drain();
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mlpbp_pkg.sv
sv/mlpbp_in_if.sv
sv/mlpbp_out_if.sv
sv/mlpbp_mac.sv
sv/mlpbp_sig.sv
sv/mlp_online_backprop.sv
dv/mlp_online_backprop_test.sv
